// File: rtl/core/tmd_pkg.sv
// Shared types and constants of the tonal masker detector.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package tmd_pkg;

    localparam int LEVEL_W      = 16;
    localparam int BIN_W        = 10;
    localparam int SPLIT_W      = 11;
    localparam int MARGIN_W     = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int MAX_BINS_DEF = 1024;

    // neighbour reach and the windows that follow from it
    localparam int REACH        = 6;
    localparam int WIN_DEPTH    = 2 * REACH + 1;
    localparam int LVL_DEPTH    = 2 * REACH;
    localparam int TONAL_DEPTH  = REACH + 1;
    localparam int LATENCY      = 2 * REACH;
    localparam int FLUSH_W      = 4;
    localparam int FIRST_TEST   = REACH + 2;

    localparam logic [SPLIT_W-1:0]  LOW_SPLIT_RST  = 11'd255;
    localparam logic [SPLIT_W-1:0]  HIGH_SPLIT_RST = 11'd510;
    localparam logic [MARGIN_W-1:0] MARGIN_RST     = 12'd448;

    typedef logic signed [LEVEL_W-1:0] level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_SPLIT  = 2'd0,
        CFG_HIGH_SPLIT = 2'd1,
        CFG_MARGIN     = 2'd2
    } cfg_idx_t;

    // encoding equals the reach in bins
    typedef enum logic [2:0] {
        REACH_NONE  = 3'd0,
        REACH_TWO   = 3'd2,
        REACH_THREE = 3'd3,
        REACH_SIX   = 3'd6
    } reach_t;

    typedef enum logic {
        ST_STREAM = 1'b0,
        ST_FLUSH  = 1'b1
    } state_t;

    typedef struct packed {
        logic [SPLIT_W-1:0]  low_split;
        logic [SPLIT_W-1:0]  high_split;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    typedef struct packed {
        logic             last_of_frame;
        logic             near_tone;
        logic             is_tonal;
        logic [BIN_W-1:0] bin_index;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/tonal_masker_detect_core.sv
// Tonal masker detector top level: configuration registers, bin window and
// result buffer. Uses tmd_pkg, tmd_bin_window and tmd_out_buf.
`default_nettype none

// Takes one spectral bin level per cycle (1/64 dB, signed) while s_tready is
// high, and reports for each bin whether it is a tonal local maximum and
// whether it lies within the reach of a tone. A bin is reported twelve bins
// after it arrives. The transaction with tlast, or the MAX_BINS-th bin, ends
// the frame and starts a flush: s_tready stays low while the twelve pending
// bins are walked out of the window. Results pass through a two-entry
// buffer, so bins keep flowing while one result waits on m_tready. Registers
// are written on the cfg channel (index 0 low split bin, 1 high split bin,
// 2 tone margin); the user must write them only while the block is idle,
// and the block itself does not enforce it.
module tonal_masker_detect_core #(
    parameter int MAX_BINS = tmd_pkg::MAX_BINS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] level_db
    input  logic        s_tlast,    // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [9:0] bin_index, [10] is_tonal, [11] near_tone
    output logic        m_tlast,    // last_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmd_pkg::CFG_DATA_W-1:0] cfg_data
);

    tmd_pkg::cfg_t    cfg_reg, cfg_next;
    tmd_pkg::push_t   push;
    tmd_pkg::result_t out_data;
    logic             push_ok;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (tmd_pkg::cfg_idx_t'(cfg_index))
                tmd_pkg::CFG_LOW_SPLIT:  cfg_next.low_split  = cfg_data[tmd_pkg::SPLIT_W-1:0];
                tmd_pkg::CFG_HIGH_SPLIT: cfg_next.high_split = cfg_data[tmd_pkg::SPLIT_W-1:0];
                tmd_pkg::CFG_MARGIN:     cfg_next.margin     = cfg_data[tmd_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_split  <= tmd_pkg::LOW_SPLIT_RST;
            cfg_reg.high_split <= tmd_pkg::HIGH_SPLIT_RST;
            cfg_reg.margin     <= tmd_pkg::MARGIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tmd_bin_window #(
        .MAX_BINS (MAX_BINS)
    ) u_bin_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_level (tmd_pkg::level_t'(s_tdata)),
        .in_end   (s_tlast),
        .in_ready (s_tready),
        .push_ok  (push_ok),
        .cfg      (cfg_reg),
        .push     (push)
    );

    tmd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_ok   (push_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {4'b0000, out_data.near_tone, out_data.is_tonal, out_data.bin_index};
    assign m_tlast = out_data.last_of_frame;

    // the window never offers a result the buffer cannot hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> push_ok)
        else $error("result offered to a full buffer");

    // a frame end always starts the flush, which holds off the next bin
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("bin accepted right after frame end");

    // a tone always lies within its own reach
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[11])
        else $error("tonal bin not marked near tone");

endmodule

`default_nettype wire

// File: rtl/core/tmd_tone_eval.sv
// Tone test on the centre bin of the level window: local maximum plus margin
// over the neighbours from two bins out to the band's reach. Uses tmd_pkg.
`default_nettype none

module tmd_tone_eval #(
    parameter int CNT_W = 10
) (
    input  tmd_pkg::level_t   win [tmd_pkg::WIN_DEPTH],
    input  logic [CNT_W-1:0]  bin_k,
    input  tmd_pkg::cfg_t     cfg,
    output tmd_pkg::reach_t   reach
);

    localparam int C     = tmd_pkg::REACH;
    localparam int CMP_W = (CNT_W > tmd_pkg::SPLIT_W) ? CNT_W : tmd_pkg::SPLIT_W;
    localparam int SUM_W = tmd_pkg::LEVEL_W + 1;

    logic signed [SUM_W-1:0] center;
    logic signed [SUM_W-1:0] marg;
    logic [C:2]              excess;
    logic                    near_ok;
    logic                    below_low;
    logic                    below_high;

    always_comb begin
        center = SUM_W'(win[C]);
        marg   = signed'({{(SUM_W - tmd_pkg::MARGIN_W){1'b0}}, cfg.margin});
        near_ok = (win[C] >= win[C-1]) && (win[C] >= win[C+1]);
        for (int d = 2; d <= C; d++) begin
            excess[d] = (center > SUM_W'(win[C-d]) + marg) &&
                        (center > SUM_W'(win[C+d]) + marg);
        end
        below_low  = CMP_W'(bin_k) < CMP_W'(cfg.low_split);
        below_high = CMP_W'(bin_k) < CMP_W'(cfg.high_split);

        reach = tmd_pkg::REACH_NONE;
        if (near_ok && excess[2]) begin
            if (below_low) begin
                reach = tmd_pkg::REACH_TWO;
            end else if (below_high) begin
                if (excess[3]) begin
                    reach = tmd_pkg::REACH_THREE;
                end
            end else if (&excess) begin
                reach = tmd_pkg::REACH_SIX;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tmd_bin_window.sv
// Bin windows (levels, near-tone marks, tonal decisions), bin counter and the
// frame-end flush sequencer. Uses tmd_pkg and tmd_tone_eval.
`default_nettype none

module tmd_bin_window #(
    parameter int MAX_BINS = tmd_pkg::MAX_BINS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  tmd_pkg::level_t    in_level,
    input  logic               in_end,
    output logic               in_ready,
    input  logic               push_ok,
    input  tmd_pkg::cfg_t      cfg,
    output tmd_pkg::push_t     push
);

    localparam int CNT_W = $clog2(MAX_BINS);
    localparam int BW    = tmd_pkg::BIN_W;
    localparam int FW    = tmd_pkg::FLUSH_W;
    localparam int C     = tmd_pkg::REACH;
    localparam int LD    = tmd_pkg::LVL_DEPTH;
    localparam int WD    = tmd_pkg::WIN_DEPTH;
    localparam int TD    = tmd_pkg::TONAL_DEPTH;

    tmd_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [FW-1:0]    flush_idx_reg, flush_idx_next;
    tmd_pkg::level_t  lvl_reg  [LD];
    tmd_pkg::level_t  lvl_next [LD];
    logic [WD-1:0]    mark_reg, mark_next;
    logic [TD-1:0]    tonal_reg, tonal_next;

    tmd_pkg::level_t  win [WD];
    tmd_pkg::reach_t  reach;
    logic [CNT_W-1:0] bin_k;
    logic             peak_hit;
    logic             accept;
    logic             frame_last;

    always_comb begin
        win[0] = in_level;
        for (int p = 1; p < WD; p++) begin
            win[p] = lvl_reg[p-1];
        end
    end

    assign bin_k = cnt_reg - CNT_W'(C);

    tmd_tone_eval #(
        .CNT_W (CNT_W)
    ) u_tone_eval (
        .win   (win),
        .bin_k (bin_k),
        .cfg   (cfg),
        .reach (reach)
    );

    assign in_ready   = (state_reg == tmd_pkg::ST_STREAM) && push_ok;
    assign accept     = in_valid && in_ready;
    assign peak_hit   = (cnt_reg >= CNT_W'(tmd_pkg::FIRST_TEST)) &&
                        (reach != tmd_pkg::REACH_NONE);
    assign frame_last = in_end || (cnt_reg == CNT_W'(MAX_BINS - 1));

    always_comb begin
        int mark_off;
        mark_off       = 0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        flush_idx_next = flush_idx_reg;
        lvl_next       = lvl_reg;
        mark_next      = mark_reg;
        tonal_next     = tonal_reg;
        push           = '0;

        case (state_reg)
            tmd_pkg::ST_STREAM: begin
                if (accept) begin
                    lvl_next[0] = in_level;
                    for (int j = 1; j < LD; j++) begin
                        lvl_next[j] = lvl_reg[j-1];
                    end
                    mark_next  = {mark_reg[WD-2:0], 1'b0};
                    for (int p = 0; p < WD; p++) begin
                        mark_off = (p > C) ? (p - C) : (C - p);
                        if (peak_hit && (int'(reach) >= mark_off)) begin
                            mark_next[p] = 1'b1;
                        end
                    end
                    tonal_next = {tonal_reg[TD-2:0], peak_hit};

                    push.valid          = cnt_reg >= CNT_W'(tmd_pkg::LATENCY);
                    push.data.bin_index = BW'(cnt_reg - CNT_W'(tmd_pkg::LATENCY));
                    push.data.is_tonal  = tonal_next[TD-1];
                    push.data.near_tone = mark_next[WD-1];

                    if (frame_last) begin
                        state_next     = tmd_pkg::ST_FLUSH;
                        flush_idx_next = FW'(tmd_pkg::LATENCY - 1);
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            tmd_pkg::ST_FLUSH: begin
                if (push_ok) begin
                    // shift zeros in, pending bins walk out of the far end
                    lvl_next[0] = '0;
                    for (int j = 1; j < LD; j++) begin
                        lvl_next[j] = lvl_reg[j-1];
                    end
                    mark_next  = {mark_reg[WD-2:0], 1'b0};
                    tonal_next = {tonal_reg[TD-2:0], 1'b0};

                    push.valid              = CNT_W'(flush_idx_reg) <= cnt_reg;
                    push.data.bin_index     = BW'(cnt_reg - CNT_W'(flush_idx_reg));
                    push.data.is_tonal      = tonal_reg[TD-2];
                    push.data.near_tone     = mark_reg[WD-2];
                    push.data.last_of_frame = flush_idx_reg == '0;

                    if (flush_idx_reg == '0) begin
                        state_next = tmd_pkg::ST_STREAM;
                        cnt_next   = '0;
                        mark_next  = '0;
                        tonal_next = '0;
                        for (int j = 0; j < LD; j++) begin
                            lvl_next[j] = '0;
                        end
                    end else begin
                        flush_idx_next = flush_idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = tmd_pkg::ST_STREAM;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmd_pkg::ST_STREAM;
            cnt_reg       <= '0;
            flush_idx_reg <= '0;
            mark_reg      <= '0;
            tonal_reg     <= '0;
            for (int j = 0; j < LD; j++) begin
                lvl_reg[j] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            flush_idx_reg <= flush_idx_next;
            mark_reg      <= mark_next;
            tonal_reg     <= tonal_next;
            lvl_reg       <= lvl_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tmd_out_buf.sv
// Two-entry result buffer between the bin window and the master side, so the
// window keeps taking bins while one result waits. Uses tmd_pkg.
`default_nettype none

module tmd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  tmd_pkg::push_t    push,
    output logic              push_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output tmd_pkg::result_t  out_data
);

    tmd_pkg::result_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ok   = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && push_ok;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire
